[rtl/core/mvr_pkg.sv]
// Package for the match vector resolver: widths, defaults and the tag bundle type.
// No dependencies; every module of the block imports it.
package mvr_pkg;

  localparam int unsigned IdxW          = 6;
  localparam int unsigned LimitW        = 7;
  localparam int unsigned TagW          = 32;
  localparam int unsigned VecPortW      = 64;
  localparam int unsigned DefMatchWidth = 64;
  localparam int unsigned QueueDepth    = 2;

  typedef struct packed {
    logic signed [TagW-1:0] a;
    logic signed [TagW-1:0] b;
    logic signed [TagW-1:0] c;
  } tags_t;

  localparam int unsigned TagsW = $bits(tags_t);

endpackage

[rtl/core/mvr_front.sv]
// Front end of the match vector resolver: takes a request, masks the vector and drops empties.
// Depends on mvr_pkg.
module mvr_front #(
  parameter int unsigned MATCH_WIDTH = mvr_pkg::DefMatchWidth
) (
  input  logic                        start,
  input  logic [mvr_pkg::VecPortW-1:0] match_bits_i,
  input  mvr_pkg::tags_t              tags_i,
  input  logic                        q_full_i,
  output logic                        busy,
  output logic                        push_o,
  output logic [MATCH_WIDTH-1:0]      vec_o,
  output mvr_pkg::tags_t              tags_o
);
  import mvr_pkg::*;

  // keep only the rows that exist
  assign vec_o  = match_bits_i[MATCH_WIDTH-1:0];
  assign tags_o = tags_i;
  assign busy   = q_full_i;
  // a vector with no matches produces nothing: accept and drop it
  assign push_o = start && !q_full_i && (vec_o != '0);

endmodule

[rtl/core/mvr_queue.sv]
// Short request queue between front and back ends of the match vector resolver.
// Depends on mvr_pkg for the default depth.
module mvr_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = mvr_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o
);
  import mvr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("request pushed into a full queue");
`endif

endmodule

[rtl/core/mvr_back.sv]
// Back end of the match vector resolver: walks one vector, one match index a cycle.
// Depends on mvr_pkg.
module mvr_back #(
  parameter int unsigned MATCH_WIDTH = mvr_pkg::DefMatchWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mvr_pkg::LimitW-1:0]  limit_i,
  input  logic                        q_valid_i,
  input  logic [MATCH_WIDTH-1:0]      q_vec_i,
  input  mvr_pkg::tags_t              q_tags_i,
  output logic                        q_pop_o,
  output logic                        res_valid_o,
  output logic [mvr_pkg::IdxW-1:0]    res_index_o,
  output mvr_pkg::tags_t              res_tags_o,
  output logic                        res_final_o
);
  import mvr_pkg::*;

  localparam int unsigned LocW = (MATCH_WIDTH > 1) ? $clog2(MATCH_WIDTH) : 1;

  logic                   active_q, active_d;
  logic [MATCH_WIDTH-1:0] vec_q, vec_d;
  tags_t                  tags_q, tags_d;
  logic [LimitW-1:0]      count_q, count_d;

  logic [MATCH_WIDTH-1:0] lowest;
  logic [MATCH_WIDTH-1:0] remain;
  logic [LocW-1:0]        loc;
  logic [LimitW-1:0]      count_inc;
  logic                   last;

  logic              out_valid_q;
  logic [IdxW-1:0]   out_index_q;
  tags_t             out_tags_q;
  logic              out_final_q;

  // isolate the lowest set bit, then encode its position
  always_comb begin
    lowest = vec_q & (~vec_q + 1'b1);
    remain = vec_q & ~lowest;
    loc    = '0;
    for (int unsigned i = 0; i < MATCH_WIDTH; i++) begin
      if (lowest[i]) begin
        loc = loc | LocW'(i);
      end
    end
    count_inc = count_q + 1'b1;
    last = active_q && ((remain == '0) || ((limit_i != '0) && (count_inc == limit_i)));
  end

  assign q_pop_o = q_valid_i && (!active_q || last);

  always_comb begin
    active_d = active_q;
    vec_d    = vec_q;
    tags_d   = tags_q;
    count_d  = count_q;
    if (q_pop_o) begin
      active_d = 1'b1;
      vec_d    = q_vec_i;
      tags_d   = q_tags_i;
      count_d  = '0;
    end else if (last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      vec_d   = remain;
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q       <= vec_d;
    tags_q      <= tags_d;
    count_q     <= count_d;
    out_index_q <= IdxW'(loc);
    out_tags_q  <= tags_q;
    out_final_q <= last;
  end

  assign res_valid_o = out_valid_q;
  assign res_index_o = out_index_q;
  assign res_tags_o  = out_tags_q;
  assign res_final_o = out_final_q;

`ifndef SYNTH
  a_active_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (vec_q != '0))
    else $error("walking an empty vector");
  a_final_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !last && !q_pop_o) |=> (active_q && $stable(tags_q)))
    else $error("walk ended without a final index");
`endif

endmodule

[rtl/core/match_vector_resolver.sv]
// Top level of the match vector resolver: limit register, front end, queue, back end.
// Depends on mvr_pkg, mvr_front, mvr_queue and mvr_back.
//
// Usage:
//   Request channel: drive match_bits_i and the three query tags with start high;
//   the request is taken at a rising edge where start is high and busy is low.
//   Result channel: result_valid_o strobes for one cycle per set bit, lowest row
//   first, with the index, the tags of its request and final_match_o on the last.
//   Limit channel: cfg_valid_i / cfg_ready_o write match_limit (0 emits every
//   match); write it only while no request is in flight.
// Timing:
//   The back end walks each vector with reported matches, one index per cycle from
//   the priority encoder. With the back end idle, a taken request is written into
//   the queue, then loaded into the walk registers, and its first index leaves
//   through the output register. Vectors with no set bits are taken and dropped
//   at once. A two-entry queue lets requests pile up while a vector is being
//   walked; busy rises when that queue is full.
// Reset:
//   rst_ni clears the queue, the walk and the limit (back to emit all).
// The receiver cannot stall: every strobed result must be taken in its cycle.
module match_vector_resolver #(
  parameter int unsigned MATCH_WIDTH = mvr_pkg::DefMatchWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic [mvr_pkg::VecPortW-1:0]       match_bits_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_a_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_b_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_c_i,
  // limit write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mvr_pkg::LimitW-1:0]         cfg_data_i,
  // result channel
  output logic                               result_valid_o,
  output logic [mvr_pkg::IdxW-1:0]           match_index_o,
  output logic signed [mvr_pkg::TagW-1:0]    result_tag_a_o,
  output logic signed [mvr_pkg::TagW-1:0]    result_tag_b_o,
  output logic signed [mvr_pkg::TagW-1:0]    result_tag_c_o,
  output logic                               final_match_o
);
  import mvr_pkg::*;

  localparam int unsigned QDataW = TagsW + MATCH_WIDTH;

  logic [LimitW-1:0]      limit_q;
  tags_t                  req_tags;
  logic                   q_full, q_push, q_valid, q_pop;
  logic [MATCH_WIDTH-1:0] fe_vec;
  tags_t                  fe_tags;
  logic [QDataW-1:0]      q_wdata, q_rdata;
  tags_t                  res_tags;

  // the limit register accepts a write every cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign req_tags.a = query_tag_a_i;
  assign req_tags.b = query_tag_b_i;
  assign req_tags.c = query_tag_c_i;

  // front end: mask to the populated rows, drop empty vectors
  mvr_front #(
    .MATCH_WIDTH(MATCH_WIDTH)
  ) u_front (
    .start       (start),
    .match_bits_i(match_bits_i),
    .tags_i      (req_tags),
    .q_full_i    (q_full),
    .busy        (busy),
    .push_o      (q_push),
    .vec_o       (fe_vec),
    .tags_o      (fe_tags)
  );

  assign q_wdata = {fe_tags, fe_vec};

  // hold pending requests while the back end walks a vector
  mvr_queue #(
    .DATA_W(QDataW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  // back end: one index per cycle, lowest first, stop at the limit
  mvr_back #(
    .MATCH_WIDTH(MATCH_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .q_valid_i  (q_valid),
    .q_vec_i    (q_rdata[MATCH_WIDTH-1:0]),
    .q_tags_i   (q_rdata[QDataW-1:MATCH_WIDTH]),
    .q_pop_o    (q_pop),
    .res_valid_o(result_valid_o),
    .res_index_o(match_index_o),
    .res_tags_o (res_tags),
    .res_final_o(final_match_o)
  );

  assign result_tag_a_o = res_tags.a;
  assign result_tag_b_o = res_tags.b;
  assign result_tag_c_o = res_tags.c;

`ifndef SYNTH
  a_final_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_match_o |-> result_valid_o)
    else $error("final flag raised without a result strobe");
`endif

endmodule

[dv/match_result_checker.sv]
// Result checker for the match vector resolver: tracks the limit register, predicts
// the indices of every accepted request and compares them with the result strobes.
// Depends on mvr_pkg for widths and the tag bundle.
`timescale 1ns / 100ps

module match_result_checker #(
  parameter int unsigned MATCH_WIDTH = mvr_pkg::DefMatchWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic [mvr_pkg::VecPortW-1:0]       match_bits_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_a_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_b_i,
  input  logic signed [mvr_pkg::TagW-1:0]    query_tag_c_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [mvr_pkg::LimitW-1:0]         cfg_data_i,
  input  logic                               result_valid_o,
  input  logic [mvr_pkg::IdxW-1:0]           match_index_o,
  input  logic signed [mvr_pkg::TagW-1:0]    result_tag_a_o,
  input  logic signed [mvr_pkg::TagW-1:0]    result_tag_b_o,
  input  logic signed [mvr_pkg::TagW-1:0]    result_tag_c_o,
  input  logic                               final_match_o,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o
);
  import mvr_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] index;
    tags_t           tags;
    logic            last_hit;
  } hit_t;

  hit_t              hits_due[$];
  logic [LimitW-1:0] limit_q;

  // Queue one entry per reported set bit, lowest row first, capped by the limit.
  task automatic queue_hits(input logic [VecPortW-1:0] rows, input tags_t tags);
    int unsigned total;
    int unsigned emitted;
    hit_t        hit;
    total   = 0;
    emitted = 0;
    for (int i = 0; i < VecPortW; i++) begin
      if (i < MATCH_WIDTH && rows[i]) total++;
    end
    if (limit_q != '0 && total > limit_q) total = 32'(limit_q);
    for (int i = 0; i < VecPortW; i++) begin
      if (i < MATCH_WIDTH && rows[i] && emitted < total) begin
        hit.index    = IdxW'(i);
        hit.tags     = tags;
        hit.last_hit = (emitted == total - 1);
        hits_due.insert(hits_due.size(), hit);
        emitted++;
      end
    end
  endtask

  task automatic compare_hit();
    hit_t want;
    hit_t seen;
    seen = {match_index_o, result_tag_a_o, result_tag_b_o, result_tag_c_o, final_match_o};
    checked_o++;
    if (hits_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t unexpected result: index %0d tags %h %h %h last %b", $realtime,
                 seen.index, seen.tags.a, seen.tags.b, seen.tags.c, seen.last_hit);
    end else begin
      want = hits_due.pop_front();
      if (seen.index !== want.index || seen.tags.a !== want.tags.a ||
          seen.tags.b !== want.tags.b || seen.tags.c !== want.tags.c ||
          seen.last_hit !== want.last_hit) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t mismatch: index %0d/%0d a %h/%h b %h/%h c %h/%h last %b/%b",
                   $realtime, want.index, seen.index, want.tags.a, seen.tags.a,
                   want.tags.b, seen.tags.b, want.tags.c, seen.tags.c,
                   want.last_hit, seen.last_hit);
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      hits_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      if (result_valid_o) compare_hit();
      if (start && !busy)
        queue_hits(match_bits_i, {query_tag_a_i, query_tag_b_i, query_tag_c_i});
      pending_o <= hits_due.size();
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the match vector resolver: clock, reset, request and limit
// stimulus, watchdog and verdict. Depends on mvr_pkg, match_vector_resolver and
// match_result_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb;
  import mvr_pkg::*;

  // Quiet cycles allowed with no request, result or limit write taken. The longest
  // correct quiet stretch is a settle hold plus a sender gap plus pipeline fill.
  localparam int unsigned QuietLimit = 2000;
  // Cycles to hold after the last expected index before touching the limit or ending.
  localparam int unsigned SettleCycles = 16;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [VecPortW-1:0]    match_bits_i;
  logic signed [TagW-1:0] query_tag_a_i;
  logic signed [TagW-1:0] query_tag_b_i;
  logic signed [TagW-1:0] query_tag_c_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [LimitW-1:0]      cfg_data_i;
  logic                   result_valid_o;
  logic [IdxW-1:0]        match_index_o;
  logic signed [TagW-1:0] result_tag_a_o;
  logic signed [TagW-1:0] result_tag_b_o;
  logic signed [TagW-1:0] result_tag_c_o;
  logic                   final_match_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned indices_checked;
  int unsigned requests_sent;
  int unsigned limit_writes;
  int unsigned burst_left;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  match_vector_resolver u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .match_bits_i,
    .query_tag_a_i,
    .query_tag_b_i,
    .query_tag_c_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .result_valid_o,
    .match_index_o,
    .result_tag_a_o,
    .result_tag_b_o,
    .result_tag_c_o,
    .final_match_o
  );

  match_result_checker u_checker (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .match_bits_i,
    .query_tag_a_i,
    .query_tag_b_i,
    .query_tag_c_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .result_valid_o,
    .match_index_o,
    .result_tag_a_o,
    .result_tag_b_o,
    .result_tag_c_o,
    .final_match_o,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (indices_checked)
  );

  // Offer one request after a random gap and hold it until the block takes it.
  // Leave start high on return: the next request, if back to back, simply
  // overwrites the payload, and anyone else must drop start themselves.
  task automatic send_request(input logic [VecPortW-1:0] rows,
                              input logic signed [TagW-1:0] tag_a,
                              input logic signed [TagW-1:0] tag_b,
                              input logic signed [TagW-1:0] tag_c);
    int unsigned gap;
    if (burst_left > 0) begin
      // inside a burst: no idling at all
      gap = 0;
      burst_left--;
    end else begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(4, 16);
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    match_bits_i  <= rows;
    query_tag_a_i <= tag_a;
    query_tag_b_i <= tag_b;
    query_tag_c_i <= tag_c;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  // Drop start, wait until every predicted index has come back, then hold for
  // SettleCycles more.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the match limit with the block idle.
  task automatic set_limit(input logic [LimitW-1:0] limit);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_writes++;
  endtask

  // Tags lean on the sign boundaries now and then; otherwise fully random.
  function automatic logic signed [TagW-1:0] rand_tag();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Vector shapes: single rows, sparse and dense random, contiguous runs,
  // the top row with scattered others, full vectors, and the odd empty one.
  function automatic logic [VecPortW-1:0] make_vector();
    logic [VecPortW-1:0] rows;
    int unsigned         lo;
    int unsigned         len;
    case ($urandom_range(0, 9))
      0:       rows = '0;
      1, 2:    rows = 64'h1 << $urandom_range(0, 63);
      3, 4:    rows = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      5, 6:    rows = {$urandom, $urandom};
      7: begin
        lo   = $urandom_range(0, 63);
        len  = $urandom_range(1, 64 - lo);
        rows = (len == 64) ? '1 : (((64'h1 << len) - 64'h1) << lo);
      end
      8:       rows = (64'h1 << $urandom_range(0, 63)) | (64'h1 << $urandom_range(0, 63)) |
                      64'h8000_0000_0000_0000;
      default: rows = '1;
    endcase
    return rows;
  endfunction

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [LimitW-1:0] phase_limits[8];
    // drive every input to a known value before the first edge
    rst_ni        = 1'b0;
    start         = 1'b0;
    match_bits_i  = '0;
    query_tag_a_i = '0;
    query_tag_b_i = '0;
    query_tag_c_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    requests_sent = 0;
    limit_writes  = 0;
    burst_left    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: the reset limit of zero emits every match. Cover the full vector,
    // the empty one, the lowest and highest row alone and alternating patterns,
    // with tags at their extremes.
    send_request('1, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1);
    send_request('0, '0, '0, '0);
    send_request(64'h1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_request(64'h8000_0000_0000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(64'haaaa_aaaa_aaaa_aaaa, -32'sd1, 32'sd0, 32'sd1);
    send_request(64'h5555_5555_5555_5555, 32'sh5a5a_a5a5, 32'sha5a5_5a5a, 32'sd7);
    send_request(64'h8000_0000_0000_0001, -32'sd2, 32'sd2, 32'sh8000_0001);
    send_request(64'hffff_0000_0000_0000, 32'sd123, -32'sd456, 32'sd789);

    // Limit of one: only the lowest row of each vector, flagged as last.
    set_limit(7'd1);
    send_request('1, 32'sd1, 32'sd2, 32'sd3);
    send_request(64'h8000_0000_0000_0000, -32'sd1, -32'sd1, -32'sd1);
    send_request('0, 32'sd9, 32'sd9, 32'sd9);

    // Limit equal to the row count, and fewer matches than the limit.
    set_limit(7'd64);
    send_request('1, 32'sd4, 32'sd5, 32'sd6);
    send_request(64'haaaa_aaaa_aaaa_aaaa, 32'sd7, 32'sd8, 32'sd9);

    // Limit beyond the row count: never more than the set bits.
    set_limit(7'd127);
    send_request('1, 32'sh7fff_ffff, '0, 32'sh8000_0000);
    send_request(64'h8000_0000_0000_0001, '0, -32'sd1, '0);

    // One short of the full vector: the top row is cut off.
    set_limit(7'd63);
    send_request('1, 32'sd11, 32'sd12, 32'sd13);

    // Limit of two on three matches.
    set_limit(7'd2);
    send_request(64'h0000_0100_0010_0001, 32'sd21, 32'sd22, 32'sd23);

    // Random phases across a spread of limits, extremes included.
    phase_limits = '{7'd3, 7'd0, 7'd64, 7'd127, 7'd1, LimitW'($urandom_range(0, 127)),
                     7'd63, LimitW'($urandom_range(0, 127))};
    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p]);
      repeat (50) send_request(make_vector(), rand_tag(), rand_tag(), rand_tag());
    end

    settle();
    $display("summary: %0d requests over %0d limit settings, %0d indices checked, %0d failures",
             requests_sent, limit_writes + 1, indices_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[match_vector_resolver.f]
rtl/core/mvr_pkg.sv
rtl/core/mvr_front.sv
rtl/core/mvr_queue.sv
rtl/core/mvr_back.sv
rtl/core/match_vector_resolver.sv
dv/match_result_checker.sv
dv/tb.sv
